[rtl/core/smte_pkg.sv]
// ============================================================================
// SPI master transfer engine package
// Shared types and codes for the transfer engine core and its checker.
// ============================================================================
package smte_pkg;

    // Frame lengths in bits.
    localparam logic [4:0] FRAME_SHORT = 5'd8;
    localparam logic [4:0] FRAME_LONG  = 5'd16;

    // Operation codes carried by a request word.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CLOCK_POLARITY = 3'd0;
    localparam logic [2:0] CFG_CLOCK_PHASE    = 3'd1;
    localparam logic [2:0] CFG_LSB_FIRST      = 3'd2;
    localparam logic [2:0] CFG_FRAME_SIXTEEN  = 3'd3;
    localparam logic [2:0] CFG_RECEIVE_ONLY   = 3'd4;
    localparam logic [2:0] CFG_BAUD_SELECT    = 3'd5;
    localparam logic [2:0] CFG_IRQ_ENABLE     = 3'd6;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] write_data;
        logic        miso;
    } req_word_t;

    typedef struct packed {
        logic        sck;
        logic        mosi;
        logic        busy_res;
        logic        rx_ready;
        logic [15:0] read_data;
        logic        irq;
    } rsp_word_t;

endpackage

[rtl/core/spi_master_transfer_engine_core.sv]
// ============================================================================
// SPI master transfer engine core
// Master-mode SPI shifter with programmable mode, frame size, bit order,
// baud divider and receive interrupt, driven one request word at a time.
// ============================================================================
// Each request word is a peripheral tick, a transmit write or a receive read,
// and every accepted word yields exactly one response word that shows the
// serial clock, MOSI, busy, ready, read data and interrupt as they stand after
// that word. The core accepts one request word per clock cycle: all of the
// state update for a word is a single combinational pass from the state
// registers into the next state and the response register, so the response
// appears in the cycle after acceptance. The only thing that holds the request
// side back is a full response register whose word is being stalled by the
// consumer; while it drains in the same cycle a new request is still taken.
// Configuration writes are always ready and take effect on the next word; a
// clock polarity write while no frame is running also moves SCK to the new
// idle level at once. The serial clock half period is 2^baud_select ticks;
// a frame of 8 or 16 bits therefore lasts 2 * bits * 2^baud_select ticks.
module spi_master_transfer_engine_core (
    input  logic                 clk,
    input  logic                 rst_n,
    // Request channel.
    input  logic                 req_valid,
    output logic                 req_stall,
    input  smte_pkg::req_word_t  req,
    // Response channel.
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output smte_pkg::rsp_word_t  rsp,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [2:0]           cfg_data
);

    // Configuration registers.
    logic       cpol_reg, cpha_reg, lsb_reg, f16_reg, rxonly_reg, irqen_reg;
    logic [2:0] baud_reg;

    // Engine state.
    logic [15:0] tx_reg, tx_next;
    logic [15:0] rx_reg, rx_next;
    logic [15:0] rbuf_reg, rbuf_next;
    logic [4:0]  bits_reg, bits_next;
    logic [6:0]  rate_reg, rate_next;
    logic        sck_reg, sck_next;
    logic        busy_reg, busy_next;
    logic        ready_reg, ready_next;

    // Response register.
    logic                rsp_valid_reg, rsp_valid_next;
    smte_pkg::rsp_word_t rsp_reg, rsp_next;

    // Scratch values of the combinational pass.
    logic        req_take;
    logic        cfg_take;
    logic [4:0]  frame_len;
    logic [7:0]  half_period;
    logic        level;
    logic [15:0] rx_sampled;
    logic [4:0]  bits_dec;
    logic        tx_bit;

    function automatic logic [15:0] frame_mask(input logic f16);
        frame_mask = f16 ? 16'hFFFF : 16'h00FF;
    endfunction

    function automatic logic [15:0] shift_tx(input logic [15:0] v, input logic lsb,
                                             input logic f16);
        logic [15:0] s;
        s = lsb ? (v >> 1) : (v << 1);
        shift_tx = s & frame_mask(f16);
    endfunction

    function automatic logic [15:0] sample_rx(input logic [15:0] v, input logic b,
                                              input logic lsb, input logic f16);
        logic [15:0] s;
        if (lsb)
        begin
            s = (v >> 1) | (f16 ? {b, 15'd0} : {8'd0, b, 7'd0});
        end
        else
        begin
            s = (v << 1) | {15'd0, b};
        end
        sample_rx = s & frame_mask(f16);
    endfunction

    // A response slot frees up when it is empty or drained this cycle.
    assign req_stall = rsp_valid_reg & rsp_stall;
    assign req_take  = req_valid & ~req_stall;
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid & cfg_ready;

    assign frame_len   = f16_reg ? smte_pkg::FRAME_LONG : smte_pkg::FRAME_SHORT;
    assign half_period = 8'd1 << baud_reg;

    always_comb
    begin
        tx_next    = tx_reg;
        rx_next    = rx_reg;
        rbuf_next  = rbuf_reg;
        bits_next  = bits_reg;
        rate_next  = rate_reg;
        sck_next   = sck_reg;
        busy_next  = busy_reg;
        ready_next = ready_reg;
        level      = ~sck_reg;
        rx_sampled = sample_rx(rx_reg, req.miso, lsb_reg, f16_reg);
        bits_dec   = (bits_reg != 5'd0) ? (bits_reg - 5'd1) : bits_reg;

        if (req_take)
        begin
            case (req.operation)
                smte_pkg::OP_TICK:
                begin
                    if (busy_reg)
                    begin
                        if (({1'b0, rate_reg} + 8'd1) >= half_period)
                        begin
                            // Divider expired: the serial clock toggles.
                            rate_next = 7'd0;
                            sck_next  = level;
                            if (level != cpol_reg)
                            begin
                                // Leading edge.
                                if (!cpha_reg)
                                begin
                                    rx_next = rx_sampled;
                                end
                                else if (bits_reg != frame_len)
                                begin
                                    tx_next = shift_tx(tx_reg, lsb_reg, f16_reg);
                                end
                            end
                            else
                            begin
                                // Trailing edge closes one bit.
                                if (!cpha_reg)
                                begin
                                    tx_next = shift_tx(tx_reg, lsb_reg, f16_reg);
                                end
                                else
                                begin
                                    rx_next = rx_sampled;
                                end
                                bits_next = bits_dec;
                                if (bits_dec == 5'd0)
                                begin
                                    rbuf_next  = cpha_reg ? rx_sampled : rx_reg;
                                    ready_next = 1'b1;
                                    busy_next  = 1'b0;
                                    sck_next   = cpol_reg;
                                end
                            end
                        end
                        else
                        begin
                            rate_next = rate_reg + 7'd1;
                        end
                    end
                end
                smte_pkg::OP_WRITE:
                begin
                    if (!busy_reg)
                    begin
                        tx_next   = req.write_data & frame_mask(f16_reg);
                        rx_next   = 16'd0;
                        bits_next = frame_len;
                        rate_next = 7'd0;
                        sck_next  = cpol_reg;
                        busy_next = 1'b1;
                    end
                end
                smte_pkg::OP_READ:
                begin
                    ready_next = 1'b0;
                end
                default:
                begin
                    // The unused code leaves all state alone.
                end
            endcase
        end

        // A polarity write while idle moves the clock to its new idle level.
        if (cfg_take && (cfg_index == smte_pkg::CFG_CLOCK_POLARITY) && !busy_reg)
        begin
            sck_next = cfg_data[0];
        end
    end

    // Response word built from the state after the request.
    always_comb
    begin
        tx_bit = lsb_reg ? tx_next[0] : (f16_reg ? tx_next[15] : tx_next[7]);

        rsp_next.sck       = sck_next;
        rsp_next.mosi      = busy_next & ~rxonly_reg & tx_bit;
        rsp_next.busy_res  = busy_next;
        rsp_next.rx_ready  = ready_next;
        rsp_next.read_data = (req.operation == smte_pkg::OP_READ) ? rbuf_reg : 16'd0;
        rsp_next.irq       = ready_next & irqen_reg;

        if (req_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpol_reg      <= 1'b0;
            cpha_reg      <= 1'b0;
            lsb_reg       <= 1'b0;
            f16_reg       <= 1'b0;
            rxonly_reg    <= 1'b0;
            baud_reg      <= 3'd0;
            irqen_reg     <= 1'b0;
            tx_reg        <= 16'd0;
            rx_reg        <= 16'd0;
            rbuf_reg      <= 16'd0;
            bits_reg      <= 5'd0;
            rate_reg      <= 7'd0;
            sck_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            ready_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_take)
            begin
                case (cfg_index)
                    smte_pkg::CFG_CLOCK_POLARITY: cpol_reg   <= cfg_data[0];
                    smte_pkg::CFG_CLOCK_PHASE:    cpha_reg   <= cfg_data[0];
                    smte_pkg::CFG_LSB_FIRST:      lsb_reg    <= cfg_data[0];
                    smte_pkg::CFG_FRAME_SIXTEEN:  f16_reg    <= cfg_data[0];
                    smte_pkg::CFG_RECEIVE_ONLY:   rxonly_reg <= cfg_data[0];
                    smte_pkg::CFG_BAUD_SELECT:    baud_reg   <= cfg_data;
                    smte_pkg::CFG_IRQ_ENABLE:     irqen_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            tx_reg        <= tx_next;
            rx_reg        <= rx_next;
            rbuf_reg      <= rbuf_next;
            bits_reg      <= bits_next;
            rate_reg      <= rate_next;
            sck_reg       <= sck_next;
            busy_reg      <= busy_next;
            ready_reg     <= ready_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // The response payload needs no reset; it is loaded with every request.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/core/smte_checker.sv]
// ============================================================================
// SPI master transfer engine checker
// Port-level assertions on the transfer engine core, bound into the core module.
// ============================================================================
module smte_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input smte_pkg::req_word_t req,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input smte_pkg::rsp_word_t rsp
);

    // A stalled response word stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // Every accepted request produces a response in the next cycle.
    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> rsp_valid)
        else $error("accepted request gave no response");

    // A read clears the ready flag seen in its response.
    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.operation == smte_pkg::OP_READ)
        |=> !rsp.rx_ready && !rsp.irq)
        else $error("ready still set after a read");

    // The interrupt only comes with ready data.
    a_irq_ready: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.irq |-> rsp.rx_ready)
        else $error("interrupt without ready data");

    // MOSI is driven only while a frame runs.
    a_mosi_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.mosi |-> rsp.busy_res)
        else $error("MOSI high while idle");

endmodule

bind spi_master_transfer_engine_core smte_checker u_smte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

[tb/sv/spi_master_transfer_engine_core_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// SPI master transfer engine core testbench
// Drives request words through the core under changing SPI settings, keeps an
// independent cycle-free model of the shifter and checks every response word.
// ============================================================================
module spi_master_transfer_engine_core_tb;

    // The fourth operation code has no meaning and must leave the core alone.
    localparam logic [1:0] OP_NONE = 2'd3;

    // Handshake pressure applied during one phase of the run.
    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_GAPS,
        FLOW_RECEIVER_STALLS,
        FLOW_BOTH
    } flow_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    smte_pkg::req_word_t req;
    logic                rsp_valid;
    logic                rsp_stall;
    smte_pkg::rsp_word_t rsp;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [2:0]          cfg_data;

    spi_master_transfer_engine_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shifter model. The settings mirror what has been written to the core,
    // the rest is the frame state as it stands after the last accepted word.
    // ------------------------------------------------------------------------
    logic        set_cpol    = 1'b0;
    logic        set_cpha    = 1'b0;
    logic        set_lsb     = 1'b0;
    logic        set_wide    = 1'b0;
    logic        set_rx_only = 1'b0;
    logic [2:0]  set_baud    = 3'd0;
    logic        set_irq_en  = 1'b0;

    logic [15:0] tx_shift    = '0;
    logic [15:0] rx_shift    = '0;
    logic [15:0] rx_buf      = '0;
    logic [4:0]  bits_left   = '0;
    logic [6:0]  div_count   = '0;
    logic        sck_level   = 1'b0;
    logic        shifting    = 1'b0;
    logic        rx_full     = 1'b0;

    // Words still waiting to go out, and the responses owed by the core.
    smte_pkg::req_word_t stim_q[$];
    smte_pkg::rsp_word_t rsp_due[$];

    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  fail_count     = 0;
    logic                req_taken      = 1'b0;
    smte_pkg::rsp_word_t want;
    string               diffs;

    function automatic logic [4:0] frame_len();
        return set_wide ? smte_pkg::FRAME_LONG : smte_pkg::FRAME_SHORT;
    endfunction

    function automatic logic [15:0] frame_mask();
        return set_wide ? 16'hFFFF : 16'h00FF;
    endfunction

    function automatic void shift_tx();
        if (set_lsb)
            tx_shift = (tx_shift >> 1) & frame_mask();
        else
            tx_shift = (tx_shift << 1) & frame_mask();
    endfunction

    function automatic void sample_rx(input logic din);
        if (set_lsb)
            rx_shift = ((rx_shift >> 1) | (16'(din) << (frame_len() - 5'd1))) & frame_mask();
        else
            rx_shift = ((rx_shift << 1) | 16'(din)) & frame_mask();
    endfunction

    // One toggle of SCK. The leading edge leaves the idle level, the trailing
    // edge returns to it; which of the two samples MISO depends on the phase.
    function automatic void sck_toggle(input logic din);
        sck_level = ~sck_level;
        if (sck_level != set_cpol)
        begin
            if (!set_cpha)
                sample_rx(din);
            else if (bits_left != frame_len())
                shift_tx();
        end
        else
        begin
            if (!set_cpha)
                shift_tx();
            else
                sample_rx(din);
            if (bits_left > 5'd0)
                bits_left = bits_left - 5'd1;
            if (bits_left == 5'd0)
            begin
                rx_buf    = rx_shift;
                rx_full   = 1'b1;
                shifting  = 1'b0;
                sck_level = set_cpol;
                div_count = '0;
            end
        end
    endfunction

    // Advances the model by one request word and returns the response that
    // the core must give for it.
    function automatic smte_pkg::rsp_word_t predict_word(input smte_pkg::req_word_t w);
        smte_pkg::rsp_word_t r;
        logic [15:0]         rdata;
        rdata = '0;
        case (w.operation)
            smte_pkg::OP_TICK:
            begin
                if (shifting)
                begin
                    if ({1'b0, div_count} + 8'd1 >= (8'd1 << set_baud))
                    begin
                        div_count = '0;
                        sck_toggle(w.miso);
                    end
                    else
                        div_count = div_count + 7'd1;
                end
            end
            smte_pkg::OP_WRITE:
            begin
                if (!shifting)
                begin
                    tx_shift  = w.write_data & frame_mask();
                    rx_shift  = '0;
                    bits_left = frame_len();
                    div_count = '0;
                    sck_level = set_cpol;
                    shifting  = 1'b1;
                end
            end
            smte_pkg::OP_READ:
            begin
                rdata   = rx_buf;
                rx_full = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.sck       = sck_level;
        r.mosi      = (shifting && !set_rx_only)
                    ? (set_lsb ? tx_shift[0] : tx_shift[frame_len() - 5'd1]) : 1'b0;
        r.busy_res  = shifting;
        r.rx_ready  = rx_full;
        r.read_data = rdata;
        r.irq       = rx_full & set_irq_en;
        return r;
    endfunction

    function automatic void apply_setting(input logic [2:0] idx, input logic [2:0] val);
        case (idx)
            smte_pkg::CFG_CLOCK_POLARITY:
            begin
                set_cpol = val[0];
                // An idle clock moves to the new level right away.
                if (!shifting)
                    sck_level = val[0];
            end
            smte_pkg::CFG_CLOCK_PHASE:    set_cpha    = val[0];
            smte_pkg::CFG_LSB_FIRST:      set_lsb     = val[0];
            smte_pkg::CFG_FRAME_SIXTEEN:  set_wide    = val[0];
            smte_pkg::CFG_RECEIVE_ONLY:   set_rx_only = val[0];
            smte_pkg::CFG_BAUD_SELECT:    set_baud    = val;
            smte_pkg::CFG_IRQ_ENABLE:     set_irq_en  = val[0];
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver. Everything the core sees changes on the falling edge. A request
    // word is held until the rising edge that takes it; only then may the
    // next one, or a gap, follow.
    // ------------------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (!req_valid || req_taken)
            begin
                if (stim_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req       <= stim_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and predictor, both on the rising edge. The response taken at
    // this edge is checked before the request word taken at the same edge is
    // modeled, since the core answers it only from its response register.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        req_taken <= rst_n && req_valid && !req_stall;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: response word with none outstanding: %p", $time, rsp);
                end
                else
                begin
                    want  = rsp_due.pop_front();
                    diffs = "";
                    if (rsp.sck !== want.sck)             diffs = {diffs, " sck"};
                    if (rsp.mosi !== want.mosi)           diffs = {diffs, " mosi"};
                    if (rsp.busy_res !== want.busy_res)   diffs = {diffs, " busy_res"};
                    if (rsp.rx_ready !== want.rx_ready)   diffs = {diffs, " rx_ready"};
                    if (rsp.read_data !== want.read_data) diffs = {diffs, " read_data"};
                    if (rsp.irq !== want.irq)             diffs = {diffs, " irq"};
                    if (diffs != "")
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch in%s: expected %p, got %p",
                                     $time, diffs, want, rsp);
                    end
                end
            end
            if (req_valid && !req_stall)
                rsp_due.push_back(predict_word(req));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic void queue_word(input logic [1:0] op, input logic [15:0] data,
                                       input logic din);
        smte_pkg::req_word_t w;
        w.operation  = op;
        w.write_data = data;
        w.miso       = din;
        stim_q.push_back(w);
    endfunction

    // Settings only change once the core has answered every word, and then a
    // further wait leaves margin for its output register.
    task automatic drain();
        while (stim_q.size() != 0 || req_valid || rsp_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [2:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        apply_setting(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly complete frames: a transmit write, enough ticks to shift every
    // bit at the current baud rate (or tick_cap at most), and usually a read
    // of the received word. Stray reads, writes while busy and dead codes are
    // sprinkled among the ticks, and short bursts of random words fill in the
    // rest. A frame that is not read leaves the next one to overrun.
    task automatic run_traffic(input int budget, input int tick_cap);
        int          queued;
        int          ticks;
        int          k;
        logic [15:0] data;
        queued = 0;
        while (queued < budget)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                case ($urandom_range(0, 9))
                    0:       data = 16'h0000;
                    1:       data = 16'hFFFF;
                    default: data = 16'($urandom);
                endcase
                queue_word(smte_pkg::OP_WRITE, data, 1'($urandom));
                ticks = 2 * frame_len() * (1 << set_baud) + $urandom_range(0, 3);
                if (ticks > tick_cap)
                    ticks = tick_cap;
                queued += ticks + 1;
                for (int i = 0; i < ticks; i++)
                begin
                    k = $urandom_range(0, 99);
                    if (k < 5)
                        queue_word(smte_pkg::OP_READ, 16'($urandom), 1'($urandom));
                    else if (k < 8)
                        queue_word(smte_pkg::OP_WRITE, 16'($urandom), 1'($urandom));
                    else if (k < 10)
                        queue_word(OP_NONE, 16'($urandom), 1'($urandom));
                    if (k < 10)
                        queued++;
                    queue_word(smte_pkg::OP_TICK, 16'($urandom), 1'($urandom));
                end
                if ($urandom_range(0, 9) < 7)
                begin
                    queue_word(smte_pkg::OP_READ, 16'($urandom), 1'($urandom));
                    queued++;
                end
            end
            else
            begin
                k = $urandom_range(1, 4);
                repeat (k) queue_word(2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
                queued += k;
            end
        end
    endtask

    // One phase: wait for quiet, pick the handshake pressure, program every
    // register and queue the traffic. A frame left running by the previous
    // phase keeps going under the new settings.
    task automatic run_phase(input flow_t flow, input logic cpol, input logic cpha,
                             input logic lsb, input logic wide, input logic rx_only,
                             input logic [2:0] baud, input logic irq_en,
                             input int budget, input int tick_cap);
        drain();
        case (flow)
            FLOW_FREE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            FLOW_SENDER_GAPS:
            begin
                send_idle_pct  = 77;
                recv_stall_pct = 0;
            end
            FLOW_RECEIVER_STALLS:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 77;
            end
            default:
            begin
                send_idle_pct  = 26;
                recv_stall_pct = 26;
            end
        endcase
        write_reg(smte_pkg::CFG_CLOCK_POLARITY, {2'b00, cpol});
        write_reg(smte_pkg::CFG_CLOCK_PHASE, {2'b00, cpha});
        write_reg(smte_pkg::CFG_LSB_FIRST, {2'b00, lsb});
        write_reg(smte_pkg::CFG_FRAME_SIXTEEN, {2'b00, wide});
        write_reg(smte_pkg::CFG_RECEIVE_ONLY, {2'b00, rx_only});
        write_reg(smte_pkg::CFG_BAUD_SELECT, baud);
        write_reg(smte_pkg::CFG_IRQ_ENABLE, {2'b00, irq_en});
        run_traffic(budget, tick_cap);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words under reset settings: a read of the empty buffer,
        // the dead code, a tick while idle, a frame of all ones with a write
        // and a read landing while it is busy, sixteen ticks of alternating
        // MISO to finish it, and the read that clears the ready flag.
        queue_word(smte_pkg::OP_READ, 16'h0000, 1'b0);
        queue_word(OP_NONE, 16'hFFFF, 1'b1);
        queue_word(smte_pkg::OP_TICK, 16'h0000, 1'b1);
        queue_word(smte_pkg::OP_WRITE, 16'hFFFF, 1'b0);
        queue_word(smte_pkg::OP_WRITE, 16'h0000, 1'b1);
        queue_word(smte_pkg::OP_READ, 16'hFFFF, 1'b0);
        for (int i = 0; i < 16; i++)
            queue_word(smte_pkg::OP_TICK, 16'h0000, i[0]);
        queue_word(smte_pkg::OP_READ, 16'h0000, 1'b0);
        drain();

        // Polarity change while idle must show on SCK with the next word.
        write_reg(smte_pkg::CFG_CLOCK_POLARITY, 3'd1);
        queue_word(smte_pkg::OP_TICK, 16'hFFFF, 1'b0);

        run_phase(FLOW_SENDER_GAPS, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0, 1'b1, 60, 4096);
        run_phase(FLOW_RECEIVER_STALLS, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 3'd1, 1'b1, 60, 4096);
        run_phase(FLOW_BOTH, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 3'd0, 1'b0, 60, 4096);
        run_phase(FLOW_FREE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 3'd2, 1'b1, 100, 4096);
        run_phase(FLOW_SENDER_GAPS, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 3'd1, 1'b1, 60, 4096);
        run_phase(FLOW_RECEIVER_STALLS, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 80, 4096);
        // Slowest divider: the tick cap falls far short of a whole frame, so the frame is
        // still running when the next phase reprograms everything.
        run_phase(FLOW_FREE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd7, 1'b0, 260, 260);
        run_phase(FLOW_BOTH, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b1, 60, 4096);
        run_phase(FLOW_SENDER_GAPS, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 80, 4096);
        run_phase(FLOW_RECEIVER_STALLS, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 80, 4096);
        run_phase(FLOW_FREE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 60, 4096);

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && rsp_due.size() == 0)
            $display("** spi_master_transfer_engine_core: PASSED **");
        else
            $display("** spi_master_transfer_engine_core: FAILED **");
        $finish;
    end

    // Watchdog for a core that stops answering.
    initial
    begin
        #3_000_000;
        $display("** spi_master_transfer_engine_core: FAILED **");
        $finish;
    end

endmodule
